FILE: rtl/core/line_edit_buffer_assert.svh
// assertion macros for the line edit buffer checker
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// same-cycle implication
`define LEB_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LEB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/leb_pkg.sv
`timescale 1ns / 1ps

package leb_pkg;

    localparam int PADDR_W = 3;

    localparam logic       REG_MAX_LENGTH = 1'b0;
    localparam logic [6:0] MAX_LEN_RESET  = 7'd64;

    localparam logic [1:0] REQ_KEY     = 2'd0;
    localparam logic [1:0] REQ_CTRL    = 2'd1;
    localparam logic [1:0] REQ_PRELOAD = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    localparam logic [3:0] KEY_LEFT      = 4'd0;
    localparam logic [3:0] KEY_RIGHT     = 4'd1;
    localparam logic [3:0] KEY_ENTER     = 4'd2;
    localparam logic [3:0] KEY_HOME      = 4'd3;
    localparam logic [3:0] KEY_END       = 4'd4;
    localparam logic [3:0] KEY_BACKSPACE = 4'd5;
    localparam logic [3:0] KEY_DELETE    = 4'd6;
    localparam logic [3:0] KEY_INSERT    = 4'd7;
    localparam logic [3:0] KEY_ESCAPE    = 4'd8;

    localparam logic [1:0] ST_EDIT    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_LINE    = 2'd2;
    localparam logic [1:0] ST_CANCEL  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] char_code;
        logic [3:0]  control_key;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  cursor_pos;
        logic [6:0]  line_length;
        logic        insert_on;
        logic [15:0] line_char;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_FINISH_INS,
        S_SHIFT_DN,
        S_EMIT
    } state_t;

endpackage

FILE: rtl/core/leb_cfg.sv
`timescale 1ns / 1ps

module leb_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [leb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [6:0]                   max_length
);
    import leb_pkg::*;

    logic [6:0] max_length_reg;
    logic       hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_MAX_LENGTH);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            max_length_reg <= pwdata[6:0];
        end
    end

    assign prdata     = hit ? {25'd0, max_length_reg} : 32'd0;
    assign max_length = max_length_reg;

endmodule

FILE: rtl/core/leb_mem.sv
`timescale 1ns / 1ps

module leb_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/leb_ctrl.sv
`timescale 1ns / 1ps

module leb_ctrl #(
    parameter int LINE_DEPTH = 64,
    parameter int CHAR_BITS  = 16,
    parameter int AW         = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  leb_pkg::req_t        req,
    output logic                 busy,
    input  logic [6:0]           max_length,
    output logic                 valid,
    output leb_pkg::rsp_t        rsp,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [CHAR_BITS-1:0] mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [CHAR_BITS-1:0] mem_rdata
);
    import leb_pkg::*;

    localparam int PW   = $clog2(LINE_DEPTH + 1);
    localparam int CW   = (CHAR_BITS < 16) ? CHAR_BITS : 16;
    localparam int CAPW = (PW > 7) ? PW : 7;

    state_t               state_reg, state_next;
    logic [PW-1:0]        cur_reg, cur_next;
    logic [PW-1:0]        len_reg, len_next;
    logic                 ins_reg, ins_next;
    logic [PW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        end_reg, end_next;
    logic [CHAR_BITS-1:0] ch_reg, ch_next;
    logic                 valid_reg, valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 emit;
    logic [1:0]           emit_status;
    logic [15:0]          emit_char;
    logic                 emit_last;
    logic [CHAR_BITS-1:0] ch_in;
    logic                 full;
    logic [PW-1:0]        cur_dec;

    assign ch_in   = CHAR_BITS'(req.char_code[CW-1:0]);
    assign full    = (CAPW'(len_reg) >= CAPW'(max_length))
                  || (CAPW'(len_reg) >= CAPW'(LINE_DEPTH));
    assign cur_dec = cur_reg - PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            len_reg   <= '0;
            ins_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            ins_reg   <= ins_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        end_reg <= end_next;
        ch_reg  <= ch_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        len_next    = len_reg;
        ins_next    = ins_reg;
        idx_next    = idx_reg;
        end_next    = end_reg;
        ch_next     = ch_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg[AW-1:0];
        mem_wdata   = ch_in;
        mem_raddr   = '0;
        emit        = 1'b0;
        emit_status = ST_EDIT;
        emit_char   = 16'd0;
        emit_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_KEY:
                        begin
                            if (ins_reg || (cur_reg == len_reg))
                            begin
                                if (full)
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_IGNORED;
                                end
                                else if (cur_reg == len_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = len_reg[AW-1:0];
                                    cur_next  = cur_reg + PW'(1);
                                    len_next  = len_reg + PW'(1);
                                    emit      = 1'b1;
                                end
                                else
                                begin
                                    ch_next    = ch_in;
                                    idx_next   = len_reg;
                                    mem_raddr  = AW'(len_reg - PW'(1));
                                    state_next = S_SHIFT_UP;
                                end
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cur_next = cur_reg + PW'(1);
                                emit     = 1'b1;
                            end
                        end
                        REQ_PRELOAD:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = ST_IGNORED;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = len_reg[AW-1:0];
                                len_next  = len_reg + PW'(1);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cur_next = '0;
                            len_next = '0;
                            emit     = 1'b1;
                        end
                        default:
                        begin
                            unique case (req.control_key)
                                KEY_LEFT:
                                begin
                                    emit = 1'b1;
                                    if (cur_reg != '0)
                                        cur_next = cur_dec;
                                    else
                                        emit_status = ST_IGNORED;
                                end
                                KEY_RIGHT:
                                begin
                                    emit = 1'b1;
                                    if (cur_reg != len_reg)
                                        cur_next = cur_reg + PW'(1);
                                    else
                                        emit_status = ST_IGNORED;
                                end
                                KEY_ENTER:
                                begin
                                    cur_next = '0;
                                    len_next = '0;
                                    if (len_reg == '0)
                                    begin
                                        emit        = 1'b1;
                                        emit_status = ST_LINE;
                                    end
                                    else
                                    begin
                                        end_next   = len_reg;
                                        idx_next   = '0;
                                        mem_raddr  = '0;
                                        state_next = S_EMIT;
                                    end
                                end
                                KEY_HOME:
                                begin
                                    cur_next = '0;
                                    emit     = 1'b1;
                                end
                                KEY_END:
                                begin
                                    cur_next = len_reg;
                                    emit     = 1'b1;
                                end
                                KEY_BACKSPACE:
                                begin
                                    if (cur_reg == '0)
                                    begin
                                        emit        = 1'b1;
                                        emit_status = ST_IGNORED;
                                    end
                                    else
                                    begin
                                        cur_next = cur_dec;
                                        if ((cur_dec + PW'(1)) >= len_reg)
                                        begin
                                            len_next = len_reg - PW'(1);
                                            emit     = 1'b1;
                                        end
                                        else
                                        begin
                                            idx_next   = cur_dec;
                                            mem_raddr  = AW'(cur_reg);
                                            state_next = S_SHIFT_DN;
                                        end
                                    end
                                end
                                KEY_DELETE:
                                begin
                                    if (cur_reg == len_reg)
                                    begin
                                        emit        = 1'b1;
                                        emit_status = ST_IGNORED;
                                    end
                                    else if ((cur_reg + PW'(1)) >= len_reg)
                                    begin
                                        len_next = len_reg - PW'(1);
                                        emit     = 1'b1;
                                    end
                                    else
                                    begin
                                        idx_next   = cur_reg;
                                        mem_raddr  = AW'(cur_reg + PW'(1));
                                        state_next = S_SHIFT_DN;
                                    end
                                end
                                KEY_INSERT:
                                begin
                                    ins_next = ~ins_reg;
                                    emit     = 1'b1;
                                end
                                KEY_ESCAPE:
                                begin
                                    cur_next    = '0;
                                    len_next    = '0;
                                    emit        = 1'b1;
                                    emit_status = ST_CANCEL;
                                end
                                default:
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_IGNORED;
                                end
                            endcase
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (idx_reg == (cur_reg + PW'(1)))
                begin
                    state_next = S_FINISH_INS;
                end
                else
                begin
                    idx_next  = idx_reg - PW'(1);
                    mem_raddr = AW'(idx_reg - PW'(2));
                end
            end
            S_FINISH_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[AW-1:0];
                mem_wdata  = ch_reg;
                cur_next   = cur_reg + PW'(1);
                len_next   = len_reg + PW'(1);
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if ((idx_reg + PW'(2)) == len_reg)
                begin
                    len_next   = len_reg - PW'(1);
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + PW'(1);
                    mem_raddr = AW'(idx_reg + PW'(2));
                end
            end
            S_EMIT:
            begin
                emit        = 1'b1;
                emit_status = ST_LINE;
                emit_char   = 16'(mem_rdata[CW-1:0]);
                emit_last   = ((idx_reg + PW'(1)) == end_reg);
                if (emit_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + PW'(1);
                    mem_raddr = AW'(idx_reg + PW'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        valid_next = emit;
        if (emit)
        begin
            rsp_next.status      = emit_status;
            rsp_next.cursor_pos  = 7'(cur_next);
            rsp_next.line_length = 7'(len_next);
            rsp_next.insert_on   = ins_next;
            rsp_next.line_char   = emit_char;
            rsp_next.last        = emit_last;
        end
        else
        begin
            rsp_next = rsp_reg;
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = valid_reg;
    assign rsp   = rsp_reg;

endmodule

FILE: rtl/core/line_edit_buffer.sv
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// request   in   start & !busy         req  (leb_pkg::req_t)
// result    out  valid, one cycle      rsp  (leb_pkg::rsp_t)
// config    in   apb psel/penable      max_length at byte address 0
//
// single-step items: result registered in the cycle after accept, busy stays low
// insert before the end: entries shift up, then the character goes in at the cursor;
// delete or backspace mid-line: shift down; enter: read, then one result per cycle
// all walks go one entry a cycle through the line memory's single read and write port
// reset clears cursor, length and mode; the line memory is not cleared
// results are not held back, the receiver takes each one in its cycle

module line_edit_buffer #(
    parameter int LINE_DEPTH = 64,
    parameter int CHAR_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  leb_pkg::req_t                req,
    output logic                         valid,
    output leb_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [leb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import leb_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [6:0]           max_length;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CHAR_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [CHAR_BITS-1:0] mem_rdata;

    leb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    leb_mem #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (CHAR_BITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    leb_ctrl #(
        .LINE_DEPTH (LINE_DEPTH),
        .CHAR_BITS  (CHAR_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .busy       (busy),
        .max_length (max_length),
        .valid      (valid),
        .rsp        (rsp),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

endmodule

FILE: rtl/core/leb_checker.sv
`timescale 1ns / 1ps
`include "line_edit_buffer_assert.svh"

module leb_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          valid,
    input  leb_pkg::rsp_t rsp
);
    import leb_pkg::*;

    // a line run delivers its words back to back
    `LEB_ASSERT_NEXT(a_run_contiguous, clk, rst_n,
        valid && !rsp.last, valid, "line run broken")

    // a non-final word only while the block is still busy
    `LEB_ASSERT_SAME(a_run_busy, clk, rst_n,
        valid && !rsp.last, busy, "run word while idle")

    // only enter words carry characters or continue
    `LEB_ASSERT_SAME(a_single_word, clk, rst_n,
        valid && (rsp.status != ST_LINE), rsp.last && (rsp.line_char == 16'd0),
        "bad single word")

    // accepted line leaves an empty line behind
    `LEB_ASSERT_SAME(a_line_empty, clk, rst_n,
        valid && (rsp.status == ST_LINE),
        (rsp.cursor_pos == 7'd0) && (rsp.line_length == 7'd0), "line not emptied")

    // every accepted item answers at once or keeps the block busy
    `LEB_ASSERT_NEXT(a_accept_progress, clk, rst_n,
        start && !busy, valid || busy, "item dropped")

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
